// File: design/nrte_pkg.sv
// Shared types and constants of the node route table engine.
// No dependencies; used by node_route_table_engine_top and the testbench.
package nrte_pkg;

  localparam int DefDestEntries = 64;
  localparam int DefBindSlots   = 8;
  localparam int DefIfaceCount  = 16;

  localparam int CallW  = 56;
  localparam int AliasW = 48;
  localparam int IfW    = 4;
  localparam int QualW  = 8;
  localparam int ObsoW  = 8;
  localparam int RankW  = 4;
  localparam int MaxW   = 3;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 8;

  localparam logic [MaxW-1:0]  MaxRoutesRst   = 3'd5;
  localparam logic [ObsoW-1:0] ObsoInitialRst = 8'd6;
  localparam logic [ObsoW-1:0] ObsoMinimumRst = 8'd5;

  typedef enum logic [1:0] {
    CmdAdd  = 2'd0,
    CmdDrop = 2'd1,
    CmdFind = 2'd2,
    CmdNone = 2'd3
  } cmd_e;

  typedef enum logic [1:0] {
    StOk       = 2'd0,
    StMiss     = 2'd1,
    StDestFull = 2'd2,
    StSlotFull = 2'd3
  } status_e;

  typedef enum logic [CfgIdxW-1:0] {
    CfgMaxRoutes   = 2'd0,
    CfgObsoInitial = 2'd1,
    CfgObsoMinimum = 2'd2,
    CfgUnused      = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    SClear, SIdle, SScan, STail, SProc, SEvict, SFind, SRemove, SWrite, SDone
  } fsm_e;

  typedef struct packed {
    logic              vld;
    logic [CallW-1:0]  nbr;
    logic [IfW-1:0]    ifc;
    logic [QualW-1:0]  qual;
    logic [ObsoW-1:0]  obso;
    logic              perm;
    logic              rec;
    logic [RankW-1:0]  rank;
  } slot_t;

  typedef struct packed {
    logic              pad;
    logic              incl;
    logic              rec;
    logic              perm;
    logic [AliasW-1:0] nalias;
    logic [QualW-1:0]  qual;
    logic [IfW-1:0]    ifc;
    logic [CallW-1:0]  nbr;
    logic [CallW-1:0]  dest;
  } in_word_t;

  typedef struct packed {
    logic              evicted;
    logic [QualW-1:0]  qual;
    logic [IfW-1:0]    ifc;
    logic [CallW-1:0]  nbr;
    logic              found;
    status_e           status;
  } out_word_t;

endpackage

// File: design/node_route_table_engine_top.sv
// Node route table engine: destination rows with neighbor bindings in one row memory.
// Depends on nrte_pkg and nrte_row_ram.
// Steps from accept to result: the row scan, a tail state, the add/drop/find decision, a
// slot walk for evict or find, removal, the row write and the output register. No new word
// is taken until the block returns to idle; the next word is taken while a result waits at the output.
// Reset: a clearing pass empties every row; registers go to 5, 6, 5.
module node_route_table_engine_top #(
  parameter int DEST_ENTRIES = nrte_pkg::DefDestEntries,
  parameter int BIND_SLOTS   = nrte_pkg::DefBindSlots,
  parameter int IFACE_COUNT  = nrte_pkg::DefIfaceCount
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // dest_call, neighbor_call, iface_num, quality, node_alias, permanent, recorded,
  // include_obsolescent, one pad bit
  input  logic [175:0]                  s_axis_tdata,
  // command
  input  logic [1:0]                    s_axis_tuser,
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // status, found, best_neighbor, best_iface, best_quality, evicted
  output logic [71:0]                   m_axis_tdata,
  input  logic                          cfg_we_i,
  input  logic [nrte_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [nrte_pkg::CfgDataW-1:0] cfg_data_i
);
  import nrte_pkg::*;

  localparam int AW   = $clog2(DEST_ENTRIES);
  localparam int SW   = $clog2(BIND_SLOTS);
  localparam int CntW = $clog2(BIND_SLOTS + 1);
  localparam int CmpW = (CntW > MaxW) ? CntW : MaxW;

  typedef struct packed {
    logic                   vld;
    logic [CntW-1:0]        cnt;
    logic [CallW-1:0]       addr;
    logic [AliasW-1:0]      nalias;
    slot_t [BIND_SLOTS-1:0] slot;
  } row_t;

  localparam int RowW = $bits(row_t);

  fsm_e       state_q, state_d;
  logic [MaxW-1:0]  max_routes_q;
  logic [ObsoW-1:0] obso_load_q, obso_min_q;

  in_word_t   in_q;
  cmd_e       cmd_q;
  logic [AW-1:0] scan_q, rd_tag_q, didx_q, fidx_q;
  logic       rd_vld_q, hit_q, free_q;
  row_t       row_q, rdata, proc_row, rem_row;
  logic [SW-1:0] sidx_q, sel_q, sel_d;
  logic       sel_vld_q, sel_vld_d;
  out_word_t  res_q, out_q;
  logic       out_vld_q;

  logic       mem_we, mem_re;
  logic [AW-1:0] mem_waddr;
  logic [RowW-1:0] mem_wdata, mem_rdata;

  // slot-level lookups on the row being processed
  row_t       rb;
  logic       bl_hit, fs_hit;
  logic [SW-1:0] bl_idx, fs_idx;
  status_e    proc_status;
  fsm_e       proc_next;
  logic       last_slot, scan_last;
  slot_t      cur;
  logic       better;
  logic [BIND_SLOTS-1:0] vld_vec;

  nrte_row_ram #(
    .Width(RowW),
    .Depth(DEST_ENTRIES)
  ) u_rows (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(scan_q),
    .rdata_o(mem_rdata)
  );

  assign rdata     = row_t'(mem_rdata);
  assign last_slot = (sidx_q == SW'(BIND_SLOTS - 1));
  assign scan_last = (scan_q == AW'(DEST_ENTRIES - 1));
  assign cur       = row_q.slot[sidx_q];

  always_comb begin
    for (int s = 0; s < BIND_SLOTS; s++) begin
      vld_vec[s] = row_q.slot[s].vld;
    end
  end

  // add / drop decision on the captured row
  always_comb begin
    rb = hit_q ? row_q : '0;
    bl_hit = 1'b0;
    bl_idx = '0;
    fs_hit = 1'b0;
    fs_idx = '0;
    for (int s = BIND_SLOTS - 1; s >= 0; s--) begin
      if (rb.slot[s].vld && rb.slot[s].nbr == in_q.nbr && rb.slot[s].ifc == in_q.ifc) begin
        bl_hit = 1'b1;
        bl_idx = SW'(s);
      end
      if (!rb.slot[s].vld) begin
        fs_hit = 1'b1;
        fs_idx = SW'(s);
      end
    end
    proc_row    = rb;
    proc_status = StMiss;
    proc_next   = SDone;
    case (cmd_q)
      CmdAdd: begin
        if ({1'b0, in_q.ifc} >= (IfW + 1)'(IFACE_COUNT)) begin
          proc_status = StMiss;
        end else if (!hit_q && !free_q) begin
          proc_status = StDestFull;
        end else if (hit_q && !bl_hit && !fs_hit) begin
          proc_status = StSlotFull;
        end else begin
          proc_status = StOk;
          if (!hit_q) begin
            proc_row.vld    = 1'b1;
            proc_row.addr   = in_q.dest;
            proc_row.nalias = in_q.nalias;
            proc_row.cnt    = '0;
          end else if (!in_q.rec) begin
            proc_row.nalias = in_q.nalias;
          end
          if (!bl_hit) begin
            for (int s = 0; s < BIND_SLOTS; s++) begin
              if (rb.slot[s].vld) begin
                proc_row.slot[s].rank = rb.slot[s].rank + RankW'(1);
              end
            end
            proc_row.slot[fs_idx] = '{vld: 1'b1, nbr: in_q.nbr, ifc: in_q.ifc,
                                      qual: in_q.qual, obso: obso_load_q, perm: in_q.perm,
                                      rec: !in_q.perm && in_q.rec, rank: '0};
            proc_row.cnt = proc_row.cnt + CntW'(1);
          end else if (in_q.perm) begin
            proc_row.slot[bl_idx].qual = in_q.qual;
            proc_row.slot[bl_idx].obso = obso_load_q;
            proc_row.slot[bl_idx].perm = 1'b1;
            proc_row.slot[bl_idx].rec  = 1'b0;
          end else if (!rb.slot[bl_idx].perm) begin
            if (!in_q.rec || rb.slot[bl_idx].rec) begin
              proc_row.slot[bl_idx].qual = in_q.qual;
              proc_row.slot[bl_idx].obso = obso_load_q;
            end
            if (!in_q.rec) begin
              proc_row.slot[bl_idx].rec = 1'b0;
            end
          end
          proc_next = (CmpW'(proc_row.cnt) > CmpW'(max_routes_q)) ? SEvict : SWrite;
        end
      end
      CmdDrop: begin
        if (hit_q && bl_hit) begin
          proc_status = StOk;
          proc_next   = SRemove;
        end
      end
      CmdFind: begin
        if (hit_q) begin
          proc_next = SFind;
        end
      end
      default: begin
        proc_status = StMiss;
      end
    endcase
  end

  // one slot per cycle for worst (evict) or best (find) selection
  always_comb begin
    better = 1'b0;
    if (state_q == SEvict) begin
      if (cur.vld && !cur.perm) begin
        better = !sel_vld_q || cur.qual < row_q.slot[sel_q].qual ||
                 (cur.qual == row_q.slot[sel_q].qual && cur.rank < row_q.slot[sel_q].rank);
      end
    end else begin
      if (cur.vld && (in_q.incl || cur.obso >= obso_min_q)) begin
        better = !sel_vld_q || cur.qual > row_q.slot[sel_q].qual ||
                 (cur.qual == row_q.slot[sel_q].qual && cur.rank < row_q.slot[sel_q].rank);
      end
    end
    sel_vld_d = sel_vld_q || better;
    sel_d     = better ? sidx_q : sel_q;
  end

  // removal of the selected binding
  always_comb begin
    rem_row = row_q;
    rem_row.slot[sel_q].vld = 1'b0;
    for (int s = 0; s < BIND_SLOTS; s++) begin
      if (row_q.slot[s].vld && row_q.slot[s].rank > row_q.slot[sel_q].rank) begin
        rem_row.slot[s].rank = row_q.slot[s].rank - RankW'(1);
      end
    end
    if (row_q.cnt != '0) begin
      rem_row.cnt = row_q.cnt - CntW'(1);
    end
    if (rem_row.cnt == '0) begin
      rem_row.vld = 1'b0;
    end
  end

  always_comb begin
    state_d       = state_q;
    s_axis_tready = (state_q == SIdle);
    mem_re        = (state_q == SScan);
    mem_we        = 1'b0;
    mem_waddr     = didx_q;
    mem_wdata     = row_q;
    case (state_q)
      SClear: begin
        mem_we    = 1'b1;
        mem_waddr = scan_q;
        mem_wdata = '0;
        if (scan_last) begin
          state_d = SIdle;
        end
      end
      SIdle: begin
        if (s_axis_tvalid) begin
          state_d = SScan;
        end
      end
      SScan: begin
        if (scan_last) begin
          state_d = STail;
        end
      end
      STail:   state_d = SProc;
      SProc:   state_d = proc_next;
      SEvict: begin
        if (last_slot) begin
          state_d = sel_vld_d ? SRemove : SWrite;
        end
      end
      SFind: begin
        if (last_slot) begin
          state_d = SDone;
        end
      end
      SRemove: state_d = SWrite;
      SWrite: begin
        mem_we  = 1'b1;
        state_d = SDone;
      end
      SDone: begin
        if (!out_vld_q || m_axis_tready) begin
          state_d = SIdle;
        end
      end
      default: state_d = SIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= SClear;
      scan_q       <= '0;
      rd_vld_q     <= 1'b0;
      hit_q        <= 1'b0;
      free_q       <= 1'b0;
      out_vld_q    <= 1'b0;
      sel_vld_q    <= 1'b0;
      max_routes_q <= MaxRoutesRst;
      obso_load_q  <= ObsoInitialRst;
      obso_min_q   <= ObsoMinimumRst;
    end else begin
      state_q  <= state_d;
      rd_vld_q <= (state_q == SScan);
      if (cfg_we_i) begin
        case (cfg_idx_e'(cfg_idx_i))
          CfgMaxRoutes:   max_routes_q <= cfg_data_i[MaxW-1:0];
          CfgObsoInitial: obso_load_q  <= cfg_data_i;
          CfgObsoMinimum: obso_min_q   <= cfg_data_i;
          default: ;
        endcase
      end
      if (state_q == SClear || state_q == SScan) begin
        scan_q <= scan_last ? '0 : scan_q + AW'(1);
      end
      if (state_q == SIdle && s_axis_tvalid) begin
        hit_q  <= 1'b0;
        free_q <= 1'b0;
      end
      if (rd_vld_q) begin
        if (rdata.vld && rdata.addr == in_q.dest && !hit_q) begin
          hit_q <= 1'b1;
        end
        if (!rdata.vld && !free_q) begin
          free_q <= 1'b1;
        end
      end
      if (state_q == SProc) begin
        sel_vld_q <= 1'b0;
      end else if (state_q == SEvict || state_q == SFind) begin
        sel_vld_q <= sel_vld_d;
      end
      if (state_q == SDone && (!out_vld_q || m_axis_tready)) begin
        out_vld_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_tag_q <= scan_q;
    if (state_q == SIdle && s_axis_tvalid) begin
      in_q  <= in_word_t'(s_axis_tdata);
      cmd_q <= cmd_e'(s_axis_tuser);
      res_q <= '0;
    end
    if (rd_vld_q) begin
      if (rdata.vld && rdata.addr == in_q.dest && !hit_q) begin
        didx_q <= rd_tag_q;
        row_q  <= rdata;
      end
      if (!rdata.vld && !free_q) begin
        fidx_q <= rd_tag_q;
      end
    end
    case (state_q)
      SProc: begin
        row_q        <= proc_row;
        didx_q       <= hit_q ? didx_q : fidx_q;
        res_q.status <= proc_status;
        sel_q        <= bl_idx;
        sidx_q       <= '0;
      end
      SEvict, SFind: begin
        sel_q  <= sel_d;
        sidx_q <= sidx_q + SW'(1);
        if (last_slot) begin
          if (state_q == SEvict) begin
            res_q.evicted <= sel_vld_d;
          end else if (sel_vld_d) begin
            res_q.status <= StOk;
            res_q.found  <= 1'b1;
            res_q.nbr    <= row_q.slot[sel_d].nbr;
            res_q.ifc    <= row_q.slot[sel_d].ifc;
            res_q.qual   <= row_q.slot[sel_d].qual;
          end else begin
            res_q.status <= StMiss;
          end
        end
      end
      SRemove: row_q <= rem_row;
      SDone: begin
        if (!out_vld_q || m_axis_tready) begin
          out_q <= res_q;
        end
      end
      default: ;
    endcase
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tdata  = out_q;

  a_row_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWrite) |-> ($countones(vld_vec) == int'(row_q.cnt)))
    else $error("row count differs from valid bindings");

  a_row_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SWrite) |-> (row_q.vld == (row_q.cnt != '0)))
    else $error("row valid does not follow binding count");

  a_read_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> $past(state_q == SScan))
    else $error("read data marked valid outside the scan");

  a_no_write_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == SScan || state_q == STail) |-> !mem_we)
    else $error("row write during destination scan");

endmodule

// File: design/nrte_row_ram.sv
// Single-port-write, single-port-read synchronous row memory with registered read data.
// No package dependencies.
module nrte_row_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: tb/node_route_table_engine_top_tb.sv
// Self-checking testbench for node_route_table_engine_top: directed and random route
// commands checked against a behavioral route table. Depends on nrte_pkg and the RTL.
module node_route_table_engine_top_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import nrte_pkg::*;

  localparam int NDest = 64;
  localparam int NSlot = 8;
  localparam int NBind = NDest * NSlot;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [175:0] s_axis_tdata = '0;
  logic [1:0] s_axis_tuser = CmdNone;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [71:0] m_axis_tdata;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = CfgMaxRoutes;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  node_route_table_engine_top dut (.*);

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // table mirror
  logic [2:0] max_routes = MaxRoutesRst;
  logic [7:0] obso_load = ObsoInitialRst;
  logic [7:0] obso_min = ObsoMinimumRst;
  bit dv[NDest];
  logic [55:0] daddr[NDest];
  int dcnt[NDest];
  bit bv[NBind];
  logic [55:0] bnbr[NBind];
  logic [3:0] bifc[NBind];
  logic [7:0] bqual[NBind];
  logic [7:0] bobso[NBind];
  bit bperm[NBind];
  bit brec[NBind];
  int brank[NBind];

  out_word_t route_results[$];
  int errors = 0;
  int words_sent = 0;
  int words_checked = 0;
  int snd_idle = 0;
  int rcv_idle = 0;
  logic [55:0] dest_pool[16];
  logic [55:0] nbr_pool[6];

  function automatic int find_dest(logic [55:0] a);
    for (int d = 0; d < NDest; d++) if (dv[d] && daddr[d] == a) return d;
    return -1;
  endfunction

  function automatic int find_bind(int d, logic [55:0] nb, logic [3:0] ifc);
    for (int s = 0; s < NSlot; s++)
      if (bv[d*NSlot+s] && bnbr[d*NSlot+s] == nb && bifc[d*NSlot+s] == ifc) return d*NSlot+s;
    return -1;
  endfunction

  function automatic int free_slot(int d);
    for (int s = 0; s < NSlot; s++) if (!bv[d*NSlot+s]) return d*NSlot+s;
    return -1;
  endfunction

  function automatic void unbind(int d, int b);
    bv[b] = 0;
    for (int s = 0; s < NSlot; s++)
      if (bv[d*NSlot+s] && brank[d*NSlot+s] > brank[b]) brank[d*NSlot+s]--;
    if (dcnt[d] > 0) dcnt[d]--;
    if (dcnt[d] == 0) dv[d] = 0;
  endfunction

  function automatic out_word_t route_update(cmd_e c, in_word_t w);
    out_word_t r;
    int d, b, o, pick;
    bit fresh;
    r = '0;
    r.status = StMiss;
    case (c)
      CmdAdd: begin
        d = find_dest(w.dest);
        fresh = (d < 0);
        if (fresh) begin
          d = -1;
          for (int i = NDest - 1; i >= 0; i--) if (!dv[i]) d = i;
          if (d < 0) begin
            r.status = StDestFull;
            return r;
          end
        end
        b = fresh ? -1 : find_bind(d, w.nbr, w.ifc);
        if (b < 0 && !fresh && free_slot(d) < 0) begin
          r.status = StSlotFull;
          return r;
        end
        r.status = StOk;
        if (fresh) begin
          dv[d] = 1;
          daddr[d] = w.dest;
          dcnt[d] = 0;
        end
        if (b < 0) begin
          b = free_slot(d);
          for (int s = 0; s < NSlot; s++) if (bv[d*NSlot+s]) brank[d*NSlot+s]++;
          bv[b] = 1; bnbr[b] = w.nbr; bifc[b] = w.ifc; bqual[b] = w.qual;
          bobso[b] = obso_load; bperm[b] = w.perm; brec[b] = !w.perm && w.rec;
          brank[b] = 0;
          dcnt[d]++;
        end else if (w.perm) begin
          bqual[b] = w.qual; bobso[b] = obso_load; bperm[b] = 1; brec[b] = 0;
        end else if (!bperm[b]) begin
          if (!w.rec || brec[b]) begin
            bqual[b] = w.qual; bobso[b] = obso_load;
          end
          if (!w.rec) brec[b] = 0;
        end
        if (dcnt[d] > max_routes) begin
          pick = -1;
          for (int s = 0; s < NSlot; s++) begin
            o = d*NSlot + s;
            if (!bv[o] || bperm[o]) continue;
            if (pick < 0 || bqual[o] < bqual[pick] ||
                (bqual[o] == bqual[pick] && brank[o] < brank[pick])) pick = o;
          end
          if (pick >= 0) begin
            unbind(d, pick);
            r.evicted = 1;
          end
        end
      end
      CmdDrop: begin
        d = find_dest(w.dest);
        b = (d < 0) ? -1 : find_bind(d, w.nbr, w.ifc);
        if (b >= 0) begin
          unbind(d, b);
          r.status = StOk;
        end
      end
      CmdFind: begin
        d = find_dest(w.dest);
        pick = -1;
        if (d >= 0)
          for (int s = 0; s < NSlot; s++) begin
            o = d*NSlot + s;
            if (!bv[o] || (!w.incl && bobso[o] < obso_min)) continue;
            if (pick < 0 || bqual[o] > bqual[pick] ||
                (bqual[o] == bqual[pick] && brank[o] < brank[pick])) pick = o;
          end
        if (pick >= 0) begin
          r.status = StOk; r.found = 1;
          r.nbr = bnbr[pick]; r.ifc = bifc[pick]; r.qual = bqual[pick];
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  // called at a rising edge; returns at the accepting edge, or later when a random idle gap follows it
  task automatic send_word(cmd_e c, logic [55:0] dest, logic [55:0] nb, logic [3:0] ifc,
                           logic [7:0] q, logic perm = 0, logic rec = 0, logic incl = 0,
                           logic [47:0] nalias = 48'h202020202020);
    in_word_t w;
    w = '0;
    w.dest = dest; w.nbr = nb; w.ifc = ifc; w.qual = q; w.nalias = nalias;
    w.perm = perm; w.rec = rec; w.incl = incl;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= w;
    s_axis_tuser <= c;
    do @(posedge clk_i); while (!s_axis_tready);
    route_results.push_back(route_update(c, w));
    words_sent++;
    if ($urandom_range(99) < snd_idle) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk_i);
    end
  endtask

  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (route_results.size() != 0) @(posedge clk_i);
    repeat (100) @(posedge clk_i);
  endtask

  task automatic write_cfg(cfg_idx_e idx, logic [7:0] val);
    settle();
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    case (idx)
      CfgMaxRoutes: max_routes = val[2:0];
      CfgObsoInitial: obso_load = val;
      CfgObsoMinimum: obso_min = val;
      default: ;
    endcase
  endtask

  always @(posedge clk_i) m_axis_tready <= ($urandom_range(99) >= rcv_idle);

  always @(posedge clk_i) begin
    out_word_t got, exp;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      words_checked++;
      if (route_results.size() == 0) begin
        $error("unexpected result word %h", m_axis_tdata);
        errors++;
      end else begin
        exp = route_results.pop_front();
        if (got.status !== exp.status) begin
          $error("status: expected %0d, got %0d", exp.status, got.status); errors++;
        end
        if (got.found !== exp.found) begin
          $error("found: expected %0d, got %0d", exp.found, got.found); errors++;
        end
        if (got.nbr !== exp.nbr) begin
          $error("best_neighbor: expected %h, got %h", exp.nbr, got.nbr); errors++;
        end
        if (got.ifc !== exp.ifc) begin
          $error("best_iface: expected %0d, got %0d", exp.ifc, got.ifc); errors++;
        end
        if (got.qual !== exp.qual) begin
          $error("best_quality: expected %0d, got %0d", exp.qual, got.qual); errors++;
        end
        if (got.evicted !== exp.evicted) begin
          $error("evicted: expected %0d, got %0d", exp.evicted, got.evicted); errors++;
        end
      end
    end
  end

  task automatic test_basic();
    logic [55:0] a, n1, n2;
    a = '1; n1 = 56'h0; n2 = '1;
    send_word(CmdFind, a, n1, 0, 0, 0, 0, 1);
    send_word(CmdAdd, a, n1, 4'hf, 8'hff, 0, 0, 0, '1);
    send_word(CmdAdd, a, n2, 0, 8'hff, 0, 1, 0, '0);
    send_word(CmdFind, a, 0, 0, 0);                 // tie goes to newest
    send_word(CmdAdd, a, n2, 0, 8'h00, 0, 1, 0);    // recorded refresh of recorded
    send_word(CmdAdd, a, n1, 4'hf, 8'h10, 0, 1, 0); // recorded cannot touch normal
    send_word(CmdFind, a, 0, 0, 0, 0, 0, 1);
    send_word(CmdAdd, a, n2, 0, 8'h80, 1, 0, 0);    // becomes permanent
    send_word(CmdAdd, a, n2, 0, 8'h01, 0, 0, 0);    // permanent holds
    send_word(CmdFind, a, 0, 0, 0);
    send_word(CmdDrop, a, n1, 4'he, 0);              // wrong interface
    send_word(CmdDrop, 56'h1, n1, 4'hf, 0);
    send_word(CmdNone, a, n1, 4'hf, 8'hff, 1, 1, 1);
    send_word(CmdDrop, a, n1, 4'hf, 0);
    send_word(CmdDrop, a, n2, 0, 0);                 // frees destination
    send_word(CmdFind, a, 0, 0, 0, 0, 0, 1);
    write_cfg(CfgObsoInitial, 8'd0);
    send_word(CmdAdd, 56'h5, 56'h9, 3, 8'd40);
    send_word(CmdFind, 56'h5, 0, 0, 0, 0, 0, 0);     // obsolescent only
    send_word(CmdFind, 56'h5, 0, 0, 0, 0, 0, 1);
    send_word(CmdDrop, 56'h5, 56'h9, 3, 0);
    write_cfg(CfgObsoInitial, 8'd255);
    write_cfg(CfgObsoMinimum, 8'd255);
  endtask

  task automatic test_eviction();
    write_cfg(CfgMaxRoutes, 8'd1);
    send_word(CmdAdd, 56'h77, 56'h1, 0, 8'd50);
    send_word(CmdAdd, 56'h77, 56'h2, 0, 8'd50);      // evicts the newer tie
    send_word(CmdAdd, 56'h77, 56'h3, 0, 8'd10);      // new one evicted
    send_word(CmdAdd, 56'h77, 56'h4, 0, 8'd5, 1);    // permanent stays, old one goes
    send_word(CmdAdd, 56'h77, 56'h5, 0, 8'd5, 1);    // nothing evictable
    send_word(CmdFind, 56'h77, 0, 0, 0, 0, 0, 1);
    write_cfg(CfgMaxRoutes, 8'd7);
    for (int i = 6; i < 13; i++) send_word(CmdAdd, 56'h77, 56'(i), 1, 8'(i), 1);
    send_word(CmdAdd, 56'h77, 56'h99, 1, 8'd1);      // slots full
    send_word(CmdFind, 56'h77, 0, 0, 0);
    for (int i = 4; i < 13; i++) send_word(CmdDrop, 56'h77, 56'(i), 4'((i < 6) ? 0 : 1), 0);
    write_cfg(CfgMaxRoutes, 8'(MaxRoutesRst));
  endtask

  task automatic test_dest_full();
    for (int i = 0; i <= NDest; i++) send_word(CmdAdd, 56'(1000 + i), 56'h3, 2, 8'(i));
    send_word(CmdFind, 56'(1000 + NDest), 0, 0, 0, 0, 0, 1);
    for (int i = 0; i < NDest; i++) send_word(CmdDrop, 56'(1000 + i), 56'h3, 2, 0);
  endtask

  task automatic test_random(int count);
    int k;
    cmd_e c;
    logic [55:0] dst, nb;
    logic [3:0] ifc;
    for (int i = 0; i < count; i++) begin
      k = $urandom_range(99);
      c = (k < 50) ? CmdAdd : (k < 70) ? CmdDrop : (k < 96) ? CmdFind : CmdNone;
      dst = ($urandom_range(19) == 0) ? 56'({$urandom, $urandom})
                                      : dest_pool[$urandom_range(15)];
      nb = ($urandom_range(19) == 0) ? 56'({$urandom, $urandom}) : nbr_pool[$urandom_range(5)];
      ifc = ($urandom_range(3) == 0) ? 4'($urandom) : 4'($urandom_range(1));
      send_word(c, dst, nb, ifc, ($urandom_range(3) == 0) ? 8'($urandom_range(3)) : 8'($urandom),
                $urandom_range(7) == 0, $urandom_range(2) == 0, 1'($urandom_range(1)),
                48'({$urandom, $urandom}));
      if (i == count / 2) settle();
    end
  endtask

  initial begin
    foreach (dest_pool[i]) dest_pool[i] = 56'({$urandom, $urandom});
    foreach (nbr_pool[i]) nbr_pool[i] = 56'({$urandom, $urandom});
    dest_pool[0] = '0; dest_pool[1] = '1; nbr_pool[0] = '0; nbr_pool[1] = '1;
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    snd_idle = 10; rcv_idle = 76;
    test_basic();
    test_eviction();
    test_dest_full();
    write_cfg(CfgObsoInitial, 8'd6);
    write_cfg(CfgObsoMinimum, 8'd5);
    test_random(160);
    snd_idle = 76; rcv_idle = 10;
    write_cfg(CfgMaxRoutes, 8'd2);
    write_cfg(CfgObsoMinimum, 8'd0);
    test_random(160);
    snd_idle = 0; rcv_idle = 0;
    write_cfg(CfgMaxRoutes, 8'd7);
    write_cfg(CfgObsoInitial, 8'd4);
    write_cfg(CfgObsoMinimum, 8'd5);
    test_random(160);
    settle();
    $display("Covered %0d words (%0d results checked): add/drop/find/undefined commands,",
             words_sent, words_checked);
    $display("eviction, full tables, obsolescence and all register settings.");
    if (errors == 0 && route_results.size() == 0) begin
      $display("node_route_table_engine_top_tb: PASS");
    end else begin
      $display("node_route_table_engine_top_tb: FAIL");
    end
    $finish;
  end

  initial begin
    #4ms;
    $display("node_route_table_engine_top_tb: FAIL");
    $finish;
  end

endmodule

// File: filelist.f
design/nrte_pkg.sv
design/nrte_row_ram.sv
design/node_route_table_engine_top.sv
tb/node_route_table_engine_top_tb.sv
